// ----- hw/rtl/irlx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlx_pkg: lexer next-state shared definitions
// State and token codes of the lexer automaton and the result word type that
// passes from the transition logic to the top level.
// ----------------------------------------------------------------------------
package irlx_pkg;

    // Field widths
    localparam int STATE_W = 6;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 4;

    // Working states
    localparam logic [STATE_W-1:0] ST_START   = 6'd0;
    localparam logic [STATE_W-1:0] ST_SYMBOL  = 6'd1;
    localparam logic [STATE_W-1:0] ST_MINUS   = 6'd2;
    localparam logic [STATE_W-1:0] ST_INT     = 6'd3;
    localparam logic [STATE_W-1:0] ST_SLASH   = 6'd4;
    localparam logic [STATE_W-1:0] ST_COMMENT = 6'd5;
    localparam logic [STATE_W-1:0] ST_EQUALS  = 6'd6;
    localparam logic [STATE_W-1:0] ST_LCURLY  = 6'd7;
    localparam logic [STATE_W-1:0] ST_RCURLY  = 6'd8;
    localparam logic [STATE_W-1:0] ST_COMMA   = 6'd9;
    localparam logic [STATE_W-1:0] ST_D       = 6'd10;
    localparam logic [STATE_W-1:0] ST_DE      = 6'd11;
    localparam logic [STATE_W-1:0] ST_DEC     = 6'd12;
    localparam logic [STATE_W-1:0] ST_DEF     = 6'd13;
    localparam logic [STATE_W-1:0] ST_G       = 6'd14;
    localparam logic [STATE_W-1:0] ST_GL      = 6'd15;
    localparam logic [STATE_W-1:0] ST_GLO     = 6'd16;
    localparam logic [STATE_W-1:0] ST_GLOB    = 6'd17;
    localparam logic [STATE_W-1:0] ST_I       = 6'd18;
    localparam logic [STATE_W-1:0] ST_I1      = 6'd19;
    localparam logic [STATE_W-1:0] ST_I8      = 6'd20;
    localparam logic [STATE_W-1:0] ST_I16     = 6'd21;
    localparam logic [STATE_W-1:0] ST_ERROR   = 6'd22;

    // Token states; token kind is the code minus the error code
    localparam logic [STATE_W-1:0] TK_EOF     = 6'd23;
    localparam logic [STATE_W-1:0] TK_SYMBOL  = 6'd24;
    localparam logic [STATE_W-1:0] TK_INT     = 6'd25;
    localparam logic [STATE_W-1:0] TK_COMMENT = 6'd26;
    localparam logic [STATE_W-1:0] TK_EQUALS  = 6'd27;
    localparam logic [STATE_W-1:0] TK_LCURLY  = 6'd28;
    localparam logic [STATE_W-1:0] TK_RCURLY  = 6'd29;
    localparam logic [STATE_W-1:0] TK_COMMA   = 6'd30;
    localparam logic [STATE_W-1:0] TK_DEC     = 6'd31;
    localparam logic [STATE_W-1:0] TK_DEF     = 6'd32;
    localparam logic [STATE_W-1:0] TK_GLOB    = 6'd33;
    localparam logic [STATE_W-1:0] TK_I8      = 6'd34;
    localparam logic [STATE_W-1:0] TK_I16     = 6'd35;

    // Token kind for "no token"
    localparam logic [KIND_W-1:0] KIND_NONE = 4'd0;

    // One result word
    typedef struct packed {
        logic               bad_state;
        logic               is_error;
        logic [KIND_W-1:0]  token_kind;
        logic [STATE_W-1:0] next_state;
    } t_lex_out;

endpackage

// ----- hw/rtl/irlx_dfa.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlx_dfa: lexer transition logic
// Combinational next-state function of the lexer automaton for one byte,
// with token kind, error and invalid-state flags.
// ----------------------------------------------------------------------------
module irlx_dfa (
    input  logic [irlx_pkg::STATE_W-1:0] i_cur_state,
    input  logic [irlx_pkg::BYTE_W-1:0]  i_in_byte,
    output irlx_pkg::t_lex_out           o_result
);
    import irlx_pkg::*;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_END     = 8'hFF;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_LCURLY  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RCURLY  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_0       = 8'h30;
    localparam logic [BYTE_W-1:0] CH_1       = 8'h31;
    localparam logic [BYTE_W-1:0] CH_6       = 8'h36;
    localparam logic [BYTE_W-1:0] CH_8       = 8'h38;
    localparam logic [BYTE_W-1:0] CH_9       = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UA      = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UZ      = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LA      = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LB      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LC      = 8'h63;
    localparam logic [BYTE_W-1:0] CH_LD      = 8'h64;
    localparam logic [BYTE_W-1:0] CH_LE      = 8'h65;
    localparam logic [BYTE_W-1:0] CH_LF_CHAR = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LG      = 8'h67;
    localparam logic [BYTE_W-1:0] CH_LI      = 8'h69;
    localparam logic [BYTE_W-1:0] CH_LL      = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_LO      = 8'h6F;
    localparam logic [BYTE_W-1:0] CH_LZ      = 8'h7A;

    logic               w_digit;
    logic               w_label;
    logic               w_space;
    logic               w_bad;
    logic [STATE_W-1:0] w_next;
    logic [STATE_W-1:0] w_kind_full;

    // Character classes
    assign w_digit = (i_in_byte >= CH_0) && (i_in_byte <= CH_9);
    assign w_label = ((i_in_byte >= CH_LA) && (i_in_byte <= CH_LZ)) ||
                     ((i_in_byte >= CH_UA) && (i_in_byte <= CH_UZ)) ||
                     w_digit || (i_in_byte == CH_UNDER);
    assign w_space = (i_in_byte == CH_SPACE) || (i_in_byte == CH_TAB) ||
                     (i_in_byte == CH_LF) || (i_in_byte == CH_CR);

    // Codes above ST_I16, including the error state code, are invalid
    assign w_bad = (i_cur_state > ST_I16);

    // Transition table
    always_comb begin
        w_next = ST_ERROR;
        unique case (i_cur_state)
            ST_START: begin
                if (w_space)                    w_next = ST_START;
                else if (i_in_byte == CH_END)     w_next = TK_EOF;
                else if (i_in_byte == CH_PERCENT) w_next = ST_SYMBOL;
                else if (i_in_byte == CH_MINUS)   w_next = ST_MINUS;
                else if (w_digit)                 w_next = ST_INT;
                else if (i_in_byte == CH_SLASH)   w_next = ST_SLASH;
                else if (i_in_byte == CH_EQUALS)  w_next = ST_EQUALS;
                else if (i_in_byte == CH_LCURLY)  w_next = ST_LCURLY;
                else if (i_in_byte == CH_RCURLY)  w_next = ST_RCURLY;
                else if (i_in_byte == CH_COMMA)   w_next = ST_COMMA;
                else if (i_in_byte == CH_LD)      w_next = ST_D;
                else if (i_in_byte == CH_LG)      w_next = ST_G;
                else if (i_in_byte == CH_LI)      w_next = ST_I;
                else                              w_next = ST_ERROR;
            end
            ST_SYMBOL:  w_next = w_label ? ST_SYMBOL : TK_SYMBOL;
            ST_MINUS:   w_next = w_digit ? ST_INT : ST_ERROR;
            ST_INT:     w_next = w_digit ? ST_INT : TK_INT;
            ST_SLASH:   w_next = (i_in_byte == CH_SLASH) ? ST_COMMENT : ST_ERROR;
            ST_COMMENT: w_next = (i_in_byte == CH_LF) ? TK_COMMENT : ST_COMMENT;
            ST_EQUALS:  w_next = TK_EQUALS;
            ST_LCURLY:  w_next = TK_LCURLY;
            ST_RCURLY:  w_next = TK_RCURLY;
            ST_COMMA:   w_next = TK_COMMA;
            ST_D:       w_next = (i_in_byte == CH_LE) ? ST_DE : ST_ERROR;
            ST_DE: begin
                if (i_in_byte == CH_LC)           w_next = ST_DEC;
                else if (i_in_byte == CH_LF_CHAR) w_next = ST_DEF;
                else                              w_next = ST_ERROR;
            end
            ST_DEC:     w_next = w_label ? ST_ERROR : TK_DEC;
            ST_DEF:     w_next = w_label ? ST_ERROR : TK_DEF;
            ST_G:       w_next = (i_in_byte == CH_LL) ? ST_GL : ST_ERROR;
            ST_GL:      w_next = (i_in_byte == CH_LO) ? ST_GLO : ST_ERROR;
            ST_GLO:     w_next = (i_in_byte == CH_LB) ? ST_GLOB : ST_ERROR;
            ST_GLOB:    w_next = w_label ? ST_ERROR : TK_GLOB;
            ST_I: begin
                if (i_in_byte == CH_1)      w_next = ST_I1;
                else if (i_in_byte == CH_8) w_next = ST_I8;
                else                        w_next = ST_ERROR;
            end
            ST_I1:      w_next = (i_in_byte == CH_6) ? ST_I16 : ST_ERROR;
            ST_I8:      w_next = w_label ? ST_ERROR : TK_I8;
            ST_I16:     w_next = w_label ? ST_ERROR : TK_I16;
            default:    w_next = ST_ERROR;
        endcase
    end

    // Derive kind and flags from the next state
    assign w_kind_full = w_next - ST_ERROR;

    always_comb begin
        o_result.next_state = w_next;
        o_result.token_kind = (w_next > ST_ERROR) ? w_kind_full[KIND_W-1:0] : KIND_NONE;
        o_result.is_error   = (w_next == ST_ERROR);
        o_result.bad_state  = w_bad;
    end

endmodule

// ----- hw/rtl/ir_lexer_next_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_lexer_next_state: lexer next-state block
// Registers one state/byte word, runs it through the transition logic and
// holds the result in an output register until it is taken.
//
//   Channel | Dir | tdata fields (low bit up)       | tuser fields (low bit up)
//   s_axis  | in  | cur_state[5:0], in_byte[13:6]   | -
//   m_axis  | out | next_state[5:0]                 | token_kind[3:0], is_error[4],
//           |     |                                 | bad_state[5]
//
// A word passes from the input register to the result register on its way
// to the output. One word is accepted every cycle while the output side
// takes words. Each stage loads when the stage after it has room,
// so a stall on m_axis fills the result register, then the input register,
// and drops s_axis_tready once both are full.
// Synchronous active-low reset clears both valid flags.
// ----------------------------------------------------------------------------
module ir_lexer_next_state (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cur_state[5:0], in_byte[13:6], zero [15:14]
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // next_state[5:0], zero [7:6]
    output logic [7:0]  m_axis_tdata,
    // token_kind[3:0], is_error[4], bad_state[5]
    output logic [5:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);
    import irlx_pkg::*;

    logic               r_in_valid;
    logic [STATE_W-1:0] r_in_state;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_lex_out           r_out;
    t_lex_out           n_out;
    logic               w_out_load;
    logic               w_in_load;

    // Output register takes a word when empty or being drained
    assign w_out_load    = r_in_valid && (!r_out_valid || m_axis_tready);
    assign w_in_load     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_in_valid || w_out_load;

    // Input register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in_state <= s_axis_tdata[STATE_W-1:0];
            r_in_byte  <= s_axis_tdata[STATE_W+BYTE_W-1:STATE_W];
        end
    end

    // Transition logic
    irlx_dfa u_dfa (
        .i_cur_state (r_in_state),
        .i_in_byte   (r_in_byte),
        .o_result    (n_out)
    );

    // Result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    // Drive the output word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.next_state};
    assign m_axis_tuser  = {r_out.bad_state, r_out.is_error, r_out.token_kind};

endmodule

// ----- hw/rtl/irlx_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irlx_checker: port checks for the lexer next-state block
// Watches the output channel for consistency of the result word and for
// holding under stall.
// ----------------------------------------------------------------------------
module irlx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [7:0]  m_axis_tdata,
    input logic [5:0]  m_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);
    import irlx_pkg::*;

    // Error flag matches the error state code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[4] == (m_axis_tdata[5:0] == ST_ERROR)))
        else $error("is_error does not match next_state");

    // Invalid input state gives the error state and no token
    a_bad_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[5]) |->
            (m_axis_tuser[4] && (m_axis_tuser[3:0] == KIND_NONE)))
        else $error("bad_state without error result");

    // Token kind is present exactly for token states
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser[3:0] != KIND_NONE) ==
                           (m_axis_tdata[5:0] > ST_ERROR)))
        else $error("token_kind does not match next_state class");

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed under stall");

    // Nothing is offered right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind ir_lexer_next_state irlx_checker u_irlx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
